/* hw/rtl/pps_pkg.sv */
`default_nettype none

package pps_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;

   localparam int SLOT_W    = 4;
   localparam int RANK_W    = 8;
   localparam int TIME_W    = 16;
   localparam int COUNT_W   = 5;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIME_W-1:0] CLOCK_MAX = '1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic REG_TASK_COUNT = 1'b0;

   typedef struct packed {
      logic load;
      logic clear;
      logic read;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
   } ctl_status_type;

endpackage

`default_nettype wire

/* hw/rtl/preemptive_priority_scheduler.sv */
// A load item is taken while idle and gives no result; loads may follow back to back.
// A tick item over N slots in use reads the table one slot at a time through the
// registered read port (scan), does the final compare (drain) and the update, then
// registers its result strobe; busy, high until the strobe cycle, holds off a new tick.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous reset clears the task count, the clock and all finished marks.
`default_nettype none

module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_command,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [RANK_W-1:0]     req_rank,
   input  wire logic [TIME_W-1:0]     req_arrival,
   input  wire logic [TIME_W-1:0]     req_burst,
   output logic                       rsp_valid,
   output logic [SLOT_W-1:0]          rsp_chosen_slot,
   output logic [TIME_W-1:0]          rsp_end_time,
   output logic                       rsp_idle,
   output logic                       rsp_slot_done,
   output logic                       rsp_all_done,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]      pwdata,
   output logic [CSR_W-1:0]           prdata,
   output logic                       pready
);

   logic [COUNT_W-1:0] task_count_ff;
   logic               csr_write;
   logic               csr_hit;
   ctl_cmd_type        cmd;
   ctl_status_type     status;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == REG_TASK_COUNT) && (paddr[1:0] == 2'b00);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? CSR_W'(task_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
      end else if (csr_write && (paddr[2] == REG_TASK_COUNT)) begin
         task_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   pps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .cmd         (cmd),
      .status      (status)
   );

   pps_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .task_count      (task_count_ff),
      .req_slot        (req_slot),
      .req_rank        (req_rank),
      .req_arrival     (req_arrival),
      .req_burst       (req_burst),
      .rsp_valid       (rsp_valid),
      .rsp_chosen_slot (rsp_chosen_slot),
      .rsp_end_time    (rsp_end_time),
      .rsp_idle        (rsp_idle),
      .rsp_slot_done   (rsp_slot_done),
      .rsp_all_done    (rsp_all_done)
   );

endmodule

`default_nettype wire

/* hw/rtl/pps_ctrl.sv */
`default_nettype none

module pps_ctrl
   import pps_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic           req_command,
   output logic                busy,
   output ctl_cmd_type         cmd,
   input  wire ctl_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_command == CMD_LOAD)) begin
               cmd.load = 1'b1;
            end
            if (start && (req_command == CMD_TICK)) begin
               cmd.clear = 1'b1;
               state_in  = status.empty ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (status.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_update_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_UPDATE))
      else $error("The update step did not follow the final compare.");

   a_update_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (state_ff == ST_IDLE))
      else $error("The controller did not return to idle after an update.");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.clear && !cmd.read && !cmd.update)
      else $error("A load coincided with a scheduling command.");

endmodule

`default_nettype wire

/* hw/rtl/pps_datapath.sv */
`default_nettype none

module pps_datapath
   import pps_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_cmd_type        cmd,
   output ctl_status_type          status,
   input  wire logic [COUNT_W-1:0] task_count,
   input  wire logic [SLOT_W-1:0]  req_slot,
   input  wire logic [RANK_W-1:0]  req_rank,
   input  wire logic [TIME_W-1:0]  req_arrival,
   input  wire logic [TIME_W-1:0]  req_burst,
   output logic                    rsp_valid,
   output logic [SLOT_W-1:0]       rsp_chosen_slot,
   output logic [TIME_W-1:0]       rsp_end_time,
   output logic                    rsp_idle,
   output logic                    rsp_slot_done,
   output logic                    rsp_all_done
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   logic [RANK_W-1:0] rank_mem [MAX_TASKS];
   logic [TIME_W-1:0] arrival_mem [MAX_TASKS];
   logic [TIME_W-1:0] remain_mem [MAX_TASKS];

   logic [MAX_TASKS-1:0] fin_ff;
   logic [TIME_W-1:0]    clock_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 stg_valid_ff;
   logic [IDX_W-1:0]     stg_idx_ff;
   logic [RANK_W-1:0]    rd_rank_ff;
   logic [TIME_W-1:0]    rd_arrival_ff;
   logic [TIME_W-1:0]    rd_remain_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [RANK_W-1:0]    best_rank_ff;
   logic [TIME_W-1:0]    best_remain_ff;
   logic [CNT_W-1:0]     unfin_cnt_ff;

   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_chosen_slot_ff;
   logic [TIME_W-1:0]    rsp_end_time_ff;
   logic                 rsp_idle_ff;
   logic                 rsp_slot_done_ff;
   logic                 rsp_all_done_ff;

   logic [CNT_W-1:0]     n_cnt;
   logic                 slot_ok;
   logic [IDX_W-1:0]     slot_idx;
   logic                 unfin;
   logic                 elig;
   logic                 take;
   logic [TIME_W-1:0]    remain_dec;
   logic                 done_now;
   logic [TIME_W-1:0]    clock_inc;

   always_comb begin
      if (int'(task_count) > MAX_TASKS) begin
         n_cnt = CNT_W'(MAX_TASKS);
      end else begin
         n_cnt = CNT_W'(task_count);
      end
   end

   assign slot_ok  = (int'(req_slot) < MAX_TASKS);
   assign slot_idx = IDX_W'(req_slot);

   assign status.empty = (n_cnt == '0);
   assign status.last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_cnt);

   assign unfin = !fin_ff[stg_idx_ff] && (rd_remain_ff != '0);
   assign elig  = unfin && (rd_arrival_ff <= clock_ff);
   assign take  = stg_valid_ff && elig && (!found_ff || (rd_rank_ff < best_rank_ff));

   assign remain_dec = best_remain_ff - TIME_W'(1);
   assign done_now   = found_ff && (remain_dec == '0);
   assign clock_inc  = (clock_ff == CLOCK_MAX) ? clock_ff : clock_ff + TIME_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load && slot_ok) begin
         rank_mem[slot_idx]    <= req_rank;
         arrival_mem[slot_idx] <= req_arrival;
         remain_mem[slot_idx]  <= req_burst;
      end else if (cmd.update && found_ff) begin
         remain_mem[best_idx_ff] <= remain_dec;
      end
      if (cmd.read) begin
         rd_rank_ff    <= rank_mem[idx_ff];
         rd_arrival_ff <= arrival_mem[idx_ff];
         rd_remain_ff  <= remain_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         stg_idx_ff <= idx_ff;
      end
      if (take) begin
         best_idx_ff    <= stg_idx_ff;
         best_rank_ff   <= rd_rank_ff;
         best_remain_ff <= rd_remain_ff;
      end
      if (cmd.update) begin
         rsp_chosen_slot_ff <= found_ff ? SLOT_W'(best_idx_ff) : '0;
         rsp_end_time_ff    <= clock_inc;
         rsp_idle_ff        <= !found_ff;
         rsp_slot_done_ff   <= done_now;
         rsp_all_done_ff    <= (unfin_cnt_ff == CNT_W'(done_now));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff       <= '0;
         clock_ff     <= '0;
         idx_ff       <= '0;
         stg_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         unfin_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= cmd.read;
         rsp_valid_ff <= cmd.update;
         if (cmd.clear) begin
            idx_ff       <= '0;
            found_ff     <= 1'b0;
            unfin_cnt_ff <= '0;
         end else begin
            if (cmd.read) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
            if (stg_valid_ff && unfin) begin
               unfin_cnt_ff <= unfin_cnt_ff + CNT_W'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load) begin
            clock_ff <= '0;
            if (slot_ok) begin
               fin_ff[slot_idx] <= 1'b0;
            end
         end
         if (cmd.update) begin
            clock_ff <= clock_inc;
            if (done_now) begin
               fin_ff[best_idx_ff] <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_slot = rsp_chosen_slot_ff;
   assign rsp_end_time    = rsp_end_time_ff;
   assign rsp_idle        = rsp_idle_ff;
   assign rsp_slot_done   = rsp_slot_done_ff;
   assign rsp_all_done    = rsp_all_done_ff;

   a_no_pending_compare: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !stg_valid_ff && !cmd.read)
      else $error("An update was issued while a compare was still pending.");

   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(cmd.load)) |-> (clock_ff >= $past(clock_ff)))
      else $error("The tick clock went backwards without a load.");

   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_idle_ff) |-> (rsp_chosen_slot_ff == '0) && !rsp_slot_done_ff)
      else $error("An idle result named a slot or a completion.");

endmodule

`default_nettype wire
